>>> rtl/cffe_pkg.sv
// cffe_pkg: shared types, constants and effect tables for the color fade/flash engine
// used by cffe_lane and color_fade_flash_engine; no dependencies
package cffe_pkg;

    localparam int CORNERS  = 4;
    localparam int COLOR_W  = 32;
    localparam int CH_W     = 8;
    localparam int STEP_W   = 8;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 136;

    // channel products: 9-bit signed difference times 9-bit signed step
    localparam int PROD_W   = 18;
    localparam int MAG_W    = 17;

    // ceil(2^17 / 3), exact floor division by three for dividends below 2^17
    localparam logic [16:0] RECIP3 = 17'd43691;

    localparam logic [COLOR_W-1:0] WFLASH_START = 32'hc0ffffff;
    localparam logic [COLOR_W-1:0] RFLASH_START = 32'hc0ff0000;
    localparam logic [COLOR_W-1:0] YFLASH_START = 32'hc0ffff00;
    localparam logic [COLOR_W-1:0] WHITE_FULL   = 32'hffffffff;
    localparam logic [COLOR_W-1:0] WHITE_HALF   = 32'h80ffffff;
    localparam logic [COLOR_W-1:0] RED_FULL     = 32'hffff0000;
    localparam logic [COLOR_W-1:0] RED_HALF     = 32'h80ff0000;
    localparam logic [COLOR_W-1:0] PAUSE_BASE   = 32'hf0000000;
    localparam logic [COLOR_W-1:0] BLACK_CLEAR  = 32'h00000000;

    localparam logic [STEP_W-1:0] LEN_FLASH = 8'd32;
    localparam logic [STEP_W-1:0] LEN_OUT   = 8'd128;
    localparam logic [STEP_W-1:0] LEN_LIGHT = 8'd64;
    localparam logic [STEP_W-1:0] LEN_FADE  = 8'd24;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_LOAD  = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        EFF_NONE     = 4'd0,
        EFF_WFLASH   = 4'd1,
        EFF_RFLASH   = 4'd2,
        EFF_YFLASH   = 4'd3,
        EFF_WOUT     = 4'd4,
        EFF_ROUT     = 4'd5,
        EFF_LIGHTUP  = 4'd6,
        EFF_LIGHTRED = 4'd7,
        EFF_PAUSEIN  = 4'd8,
        EFF_FADEOUT  = 4'd9
    } effect_t;

    typedef enum logic [1:0] {
        DIV_24,
        DIV_32,
        DIV_64,
        DIV_128
    } div_t;

    typedef struct packed {
        logic              go;
        logic [STEP_W-1:0] step;
        div_t              div;
    } lane_ctl_t;

    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] color;
    } lane_res_t;

    function automatic logic [STEP_W-1:0] fx_length(effect_t eff, logic [STEP_W-1:0] cur);
        logic [STEP_W-1:0] len;
        len = cur;
        case (eff)
            EFF_WFLASH, EFF_RFLASH, EFF_YFLASH: len = LEN_FLASH;
            EFF_WOUT, EFF_ROUT:                 len = LEN_OUT;
            EFF_LIGHTUP, EFF_LIGHTRED:          len = LEN_LIGHT;
            EFF_PAUSEIN, EFF_FADEOUT:           len = LEN_FADE;
            default:                            len = cur;
        endcase
        return len;
    endfunction

    function automatic logic [COLOR_W-1:0] fx_start(effect_t eff, int idx,
                                                    logic [COLOR_W-1:0] base,
                                                    logic [COLOR_W-1:0] cur);
        logic [COLOR_W-1:0] s;
        s = cur;
        case (eff)
            EFF_WFLASH:               s = WFLASH_START;
            EFF_RFLASH:               s = RFLASH_START;
            EFF_YFLASH:               s = YFLASH_START;
            EFF_WOUT:                 s = (idx < 2) ? WHITE_FULL : WHITE_HALF;
            EFF_ROUT:                 s = (idx < 2) ? RED_FULL : RED_HALF;
            EFF_LIGHTUP:              s = BLACK_CLEAR;
            EFF_LIGHTRED:             s = RED_FULL;
            EFF_PAUSEIN, EFF_FADEOUT: s = base;
            default:                  s = cur;
        endcase
        return s;
    endfunction

    function automatic logic [COLOR_W-1:0] fx_base(effect_t eff, logic [COLOR_W-1:0] base);
        logic [COLOR_W-1:0] b;
        b = base;
        case (eff)
            EFF_LIGHTUP, EFF_LIGHTRED: b = WHITE_FULL;
            EFF_PAUSEIN:               b = PAUSE_BASE;
            EFF_FADEOUT:               b = BLACK_CLEAR;
            default:                   b = base;
        endcase
        return b;
    endfunction

    function automatic div_t div_code(logic [STEP_W-1:0] len);
        div_t d;
        case (len)
            LEN_FADE:  d = DIV_24;
            LEN_FLASH: d = DIV_32;
            LEN_LIGHT: d = DIV_64;
            default:   d = DIV_128;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/cffe_lane.sv
// cffe_lane: one corner's interpolation lane, walks the four ARGB channels in turn
// two stages per channel: difference times step, then signed divide by length plus origin
// depends on cffe_pkg
module cffe_lane import cffe_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctl_t          ctl,
    input  logic [COLOR_W-1:0] base_color,
    input  logic [COLOR_W-1:0] org_color,
    output lane_res_t          res
);

    logic                     busy_reg, busy_next;
    logic [1:0]               ch_reg, ch_next;
    logic                     v2_reg, v2_next;
    logic [1:0]               ch2_reg, ch2_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [CH_W-1:0]          org_ch_reg, org_ch_next;
    logic [COLOR_W-1:0]       color_reg, color_next;
    logic                     done_reg, done_next;

    logic [CH_W-1:0]          tgt_ch, org_ch;
    logic signed [CH_W:0]     diff;
    logic                     neg;
    logic [PROD_W-1:0]        mag_full;
    logic [MAG_W-1:0]         mag;
    logic [13:0]              mag_div8;
    logic [30:0]              recip_prod;
    logic [MAG_W-1:0]         quo;
    logic [PROD_W-1:0]        sum;

    assign tgt_ch = base_color[ch_reg*CH_W +: CH_W];
    assign org_ch = org_color[ch_reg*CH_W +: CH_W];
    assign diff   = $signed({1'b0, tgt_ch}) - $signed({1'b0, org_ch});

    // truncation toward zero: divide the magnitude, then restore the sign
    assign neg        = prod_reg[PROD_W-1];
    assign mag_full   = neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign mag        = mag_full[MAG_W-1:0];
    assign mag_div8   = 14'(mag >> 3);
    assign recip_prod = 31'(mag_div8 * RECIP3);

    always_comb begin
        case (ctl.div)
            DIV_24:  quo = MAG_W'(recip_prod >> 17);
            DIV_32:  quo = mag >> 5;
            DIV_64:  quo = mag >> 6;
            DIV_128: quo = mag >> 7;
            default: quo = mag >> 7;
        endcase
    end

    assign sum = (neg ? (PROD_W'(0) - {1'b0, quo}) : {1'b0, quo})
                 + {{(PROD_W-CH_W){1'b0}}, org_ch_reg};

    always_comb begin
        busy_next   = busy_reg;
        ch_next     = ch_reg;
        v2_next     = 1'b0;
        ch2_next    = ch_reg;
        prod_next   = prod_reg;
        org_ch_next = org_ch_reg;
        color_next  = color_reg;
        done_next   = 1'b0;

        if (ctl.go) begin
            busy_next = 1'b1;
            ch_next   = 2'd0;
        end else if (busy_reg) begin
            v2_next     = 1'b1;
            prod_next   = PROD_W'(diff * $signed({1'b0, ctl.step}));
            org_ch_next = org_ch;
            ch_next     = ch_reg + 2'd1;
            if (ch_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end

        if (v2_reg) begin
            color_next[ch2_reg*CH_W +: CH_W] = sum[CH_W-1:0];
            done_next = (ch2_reg == 2'd3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ch_reg   <= 2'd0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ch_reg   <= ch_next;
            v2_reg   <= v2_next;
            done_reg <= done_next;
        end
        ch2_reg    <= ch2_next;
        prod_reg   <= prod_next;
        org_ch_reg <= org_ch_next;
        color_reg  <= color_next;
    end

    assign res.done  = done_reg;
    assign res.color = color_reg;

endmodule

>>> rtl/color_fade_flash_engine.sv
// color_fade_flash_engine: four-corner ARGB fade/flash engine, top level and merge stage
// sequence: load, start and idle ticks go from idle straight to the output state;
// a tick that interpolates goes through evaluate, the lanes (one lane per corner,
// 4 channels through a 2-stage multiply/divide lane) and output; a tick that ends
// an effect skips the lanes; throughput: one item at a time, the next transfer is
// taken once the result is in the output register
// aresetn (synchronous) restores all colors and stops any effect
module color_fade_flash_engine import cffe_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // opcode[1:0], effect[5:2], corner[7:6], argb_in[39:8]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // shown_color_0[31:0], shown_color_1[63:32], shown_color_2[95:64],
    // shown_color_3[127:96], effect_busy[128], zero fill above
    output logic [OUT_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CALC,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [COLOR_W-1:0] base_reg  [CORNERS], base_next  [CORNERS];
    logic [COLOR_W-1:0] start_reg [CORNERS], start_next [CORNERS];
    logic [COLOR_W-1:0] shown_reg [CORNERS], shown_next [CORNERS];
    effect_t            active_reg, active_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  len_reg, len_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;

    opcode_t            in_op;
    effect_t            in_eff;
    logic [1:0]         in_corner;
    logic [COLOR_W-1:0] in_argb;
    logic [STEP_W-1:0]  step_inc;
    logic               lane_go;
    lane_ctl_t          lane_ctl;
    lane_res_t          lane_res [CORNERS];
    logic [OUT_W-1:0]   out_word;

    assign in_op     = opcode_t'(s_tdata[1:0]);
    assign in_eff    = effect_t'(s_tdata[5:2]);
    assign in_corner = s_tdata[7:6];
    assign in_argb   = s_tdata[39:8];
    assign step_inc  = step_reg + 8'd1;

    assign s_tready = (state_reg == S_IDLE);

    assign lane_ctl.go   = lane_go;
    assign lane_ctl.step = step_reg;
    assign lane_ctl.div  = div_code(len_reg);

    for (genvar i = 0; i < CORNERS; i++) begin : g_lane
        cffe_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (lane_ctl),
            .base_color (base_reg[i]),
            .org_color  (start_reg[i]),
            .res        (lane_res[i])
        );
    end

    always_comb begin
        out_word = '0;
        for (int j = 0; j < 4; j++) begin
            if (j < CORNERS) begin
                out_word[j*COLOR_W +: COLOR_W] = shown_reg[j];
            end
        end
        out_word[4*COLOR_W] = (active_reg != EFF_NONE);
    end

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        start_next   = start_reg;
        shown_next   = shown_reg;
        active_next  = active_reg;
        step_next    = step_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        lane_go      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_OUT;
                    case (in_op)
                        OP_TICK: begin
                            if (active_reg != EFF_NONE) begin
                                step_next  = step_inc;
                                state_next = S_EVAL;
                                // first step of an effect loads its colors and length
                                if (step_inc == 8'd1) begin
                                    len_next = fx_length(active_reg, len_reg);
                                    for (int i = 0; i < CORNERS; i++) begin
                                        start_next[i] = fx_start(active_reg, i, base_reg[i],
                                                                 start_reg[i]);
                                        base_next[i]  = fx_base(active_reg, base_reg[i]);
                                    end
                                end
                            end
                        end
                        OP_START: begin
                            active_next = (in_eff <= EFF_FADEOUT) ? in_eff : EFF_NONE;
                            step_next   = '0;
                        end
                        OP_LOAD: begin
                            for (int i = 0; i < CORNERS; i++) begin
                                if (int'(in_corner) == i) begin
                                    base_next[i]  = in_argb;
                                    shown_next[i] = in_argb;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL: begin
                if (step_reg < len_reg) begin
                    lane_go    = 1'b1;
                    state_next = S_CALC;
                end else begin
                    if (step_reg == len_reg) begin
                        shown_next  = base_reg;
                        step_next   = '0;
                        active_next = EFF_NONE;
                    end
                    state_next = S_OUT;
                end
            end
            S_CALC: begin
                // lanes run in lockstep, lane zero speaks for all
                if (lane_res[0].done) begin
                    for (int i = 0; i < CORNERS; i++) begin
                        shown_next[i] = lane_res[i].color;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = out_word;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= EFF_NONE;
            step_reg    <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CORNERS; i++) begin
                base_reg[i]  <= WHITE_FULL;
                start_reg[i] <= '0;
                shown_reg[i] <= WHITE_FULL;
            end
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            step_reg    <= step_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            base_reg    <= base_next;
            start_reg   <= start_next;
            shown_reg   <= shown_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> test/tb_color_fade_flash_engine.sv
// tb_color_fade_flash_engine: self-checking bench for the four-corner fade/flash engine
// predicts every shown frame in a scoreboard class and compares the output stream to it;
// needs cffe_pkg and color_fade_flash_engine from rtl
`timescale 1ns / 100ps

module tb_color_fade_flash_engine;
    import cffe_pkg::*;

    localparam int N_ITEMS     = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic            busy;
        logic [3:0][31:0] color;
    } shown_frame_t;

    class fade_scoreboard;
        logic [31:0] base_col[4];
        logic [31:0] start_col[4];
        logic [31:0] shown_col[4];
        effect_t     running_fx;
        logic [7:0]  step_cnt;
        logic [7:0]  fx_len;
        shown_frame_t frames_due[$];
        int errors;
        int frames_checked;
        int fx_finished;

        function new();
            int i;
            for (i = 0; i < 4; i++) begin
                base_col[i]  = 32'hffffffff;
                start_col[i] = 32'h00000000;
                shown_col[i] = 32'hffffffff;
            end
            running_fx = EFF_NONE;
            step_cnt = 8'd0;
            fx_len = 8'd0;
            errors = 0;
            frames_checked = 0;
            fx_finished = 0;
        endfunction

        // one channel: (target - origin) * step / length + origin, truncating division
        function logic [7:0] blend(logic [7:0] tgt, logic [7:0] org);
            int t, o, v;
            t = int'(tgt);
            o = int'(org);
            v = (t - o) * int'(step_cnt) / int'(fx_len) + o;
            return v[7:0];
        endfunction

        function void load_fx_table();
            int i;
            for (i = 0; i < 4; i++) begin
                case (running_fx)
                    EFF_WFLASH: begin fx_len = 8'd32; start_col[i] = 32'hc0ffffff; end
                    EFF_RFLASH: begin fx_len = 8'd32; start_col[i] = 32'hc0ff0000; end
                    EFF_YFLASH: begin fx_len = 8'd32; start_col[i] = 32'hc0ffff00; end
                    EFF_WOUT: begin
                        fx_len = 8'd128;
                        start_col[i] = (i < 2) ? 32'hffffffff : 32'h80ffffff;
                    end
                    EFF_ROUT: begin
                        fx_len = 8'd128;
                        start_col[i] = (i < 2) ? 32'hffff0000 : 32'h80ff0000;
                    end
                    EFF_LIGHTUP: begin
                        fx_len = 8'd64;
                        start_col[i] = 32'h00000000;
                        base_col[i] = 32'hffffffff;
                    end
                    EFF_LIGHTRED: begin
                        fx_len = 8'd64;
                        start_col[i] = 32'hffff0000;
                        base_col[i] = 32'hffffffff;
                    end
                    EFF_PAUSEIN: begin
                        fx_len = 8'd24;
                        start_col[i] = base_col[i];
                        base_col[i] = 32'hf0000000;
                    end
                    EFF_FADEOUT: begin
                        fx_len = 8'd24;
                        start_col[i] = base_col[i];
                        base_col[i] = 32'h00000000;
                    end
                    default: ;
                endcase
            end
        endfunction

        function void frame_tick();
            int i, c;
            if (running_fx == EFF_NONE) return;
            step_cnt = step_cnt + 8'd1;
            if (step_cnt == 8'd1) load_fx_table();
            if (step_cnt < fx_len) begin
                for (i = 0; i < 4; i++)
                    for (c = 0; c < 4; c++)
                        shown_col[i][8*c +: 8] = blend(base_col[i][8*c +: 8],
                                                       start_col[i][8*c +: 8]);
            end
            if (step_cnt == fx_len) begin
                for (i = 0; i < 4; i++) shown_col[i] = base_col[i];
                step_cnt = 8'd0;
                running_fx = EFF_NONE;
                fx_finished++;
            end
        endfunction

        function void note_input(logic [IN_W-1:0] item);
            logic [1:0]  op;
            logic [3:0]  eff;
            logic [1:0]  cor;
            logic [31:0] argb;
            shown_frame_t want;
            int i;
            op   = item[1:0];
            eff  = item[5:2];
            cor  = item[7:6];
            argb = item[39:8];
            case (op)
                OP_TICK:  frame_tick();
                OP_START: begin
                    // codes above fade out behave as no effect
                    running_fx = (eff <= EFF_FADEOUT) ? effect_t'(eff) : EFF_NONE;
                    step_cnt = 8'd0;
                end
                OP_LOAD: begin
                    base_col[cor]  = argb;
                    shown_col[cor] = argb;
                end
                default: ;
            endcase
            for (i = 0; i < 4; i++) want.color[i] = shown_col[i];
            want.busy = (running_fx != EFF_NONE);
            frames_due.push_back(want);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            shown_frame_t want;
            int i;
            if (frames_due.size() == 0) begin
                $error("result transfer with no frame expected: %h", data);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            for (i = 0; i < 4; i++)
                if (data[32*i +: 32] !== want.color[i]) begin
                    $error("shown_color_%0d: expected %08h, got %08h",
                           i, want.color[i], data[32*i +: 32]);
                    errors++;
                end
            if (data[128] !== want.busy) begin
                $error("effect_busy: expected %0b, got %0b", want.busy, data[128]);
                errors++;
            end
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [OUT_W-1:0] m_tdata;

    logic calm;
    logic hold_req;
    int   items_sent;
    int   cycle_count;
    fade_scoreboard sb;

    color_fade_flash_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [3:0] eff, logic [1:0] cor,
                             logic [31:0] argb);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {argb, cor, eff, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(s_tdata);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 4'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic send_start(logic [3:0] eff);
        send_item(OP_START, eff, 2'($urandom), $urandom);
    endtask

    task automatic send_load(logic [1:0] cor, logic [31:0] argb);
        send_item(OP_LOAD, 4'($urandom), cor, argb);
    endtask

    // up to four loads, one effect, then a run of mostly ticks that often reaches the end
    task automatic run_effect();
        int n, k;
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) send_load(2'($urandom), pick_color());
        send_start(4'($urandom_range(EFF_WFLASH, EFF_FADEOUT)));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(20, 140);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 99))
                0:       send_load(2'($urandom), pick_color());
                1:       send_start(4'($urandom));
                2:       send_item(OP_UNUSED, 4'($urandom), 2'($urandom), $urandom);
                default: send_tick();
            endcase
        end
    endtask

    task automatic send_noise();
        int n, k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_item(2'($urandom), 4'($urandom), 2'($urandom), pick_color());
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        logic hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int e;
        logic paused;
        sb = new();
        items_sent = 0;
        paused = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        calm     <= 1'b0;
        hold_req <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: color extremes, unused codes, every effect started, all but the first mid-run
        send_load(2'd0, 32'h00000000);
        send_load(2'd1, 32'hffffffff);
        send_load(2'd2, 32'h5a5aa5a5);
        send_load(2'd3, 32'ha5a55a5a);
        send_item(OP_UNUSED, 4'hf, 2'd3, 32'hffffffff);
        send_start(4'hf);
        send_tick();
        for (e = EFF_WFLASH; e <= EFF_FADEOUT; e++) begin
            send_start(4'(e));
            send_tick();
            if (e == EFF_PAUSEIN) send_load(2'd1, 32'h80808080);
        end
        send_start(EFF_NONE);
        send_tick();

        while (items_sent < N_ITEMS) begin
            if (items_sent >= 300) hold_req <= 1'b1;
            if (items_sent >= 700 && items_sent < 1100) calm <= 1'b1;
            else calm <= 1'b0;
            if (!paused && items_sent >= 1300) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.frames_due.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 9) < 8) run_effect();
            else send_noise();
        end
        s_tvalid <= 1'b0;
        calm <= 1'b0;

        while (sb.frames_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d items sent, %0d frames checked, %0d effects ran to their end",
                 items_sent, sb.frames_checked, sb.fx_finished);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/cffe_pkg.sv
rtl/cffe_lane.sv
rtl/color_fade_flash_engine.sv
test/tb_color_fade_flash_engine.sv
